/* sv/philox_counter_rng_assert.svh */
// ----------------------------------------------------------------------------
// Philox counter RNG assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PHILOX_COUNTER_RNG_ASSERT_SVH
`define PHILOX_COUNTER_RNG_ASSERT_SVH

// Same-cycle implication.
`define PHX_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("philox_counter_rng: same-cycle check failed");

// Next-cycle implication.
`define PHX_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("philox_counter_rng: next-cycle check failed");

`endif

/* sv/phx_pkg.sv */
// ----------------------------------------------------------------------------
// Philox counter RNG package
// Constants, register codes and the pipeline item type shared by the block.
// ----------------------------------------------------------------------------
package phx_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 4;
  localparam int RCNT_W     = 5;
  localparam int MAX_ROUNDS = 16;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [WORD_W-1:0] MUL_A  = 32'hD251_1F53;
  localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E_8D57;
  localparam logic [WORD_W-1:0] WEYL_A = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] WEYL_B = 32'hBB67_AE85;

  localparam logic [RCNT_W-1:0] ROUNDS_RESET = 5'd10;
  localparam logic [RCNT_W-1:0] ROUNDS_MAX   = RCNT_W'(MAX_ROUNDS);

  typedef logic [WORD_W-1:0] word_t;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_KEY0   = 2'd0,
    REG_KEY1   = 2'd1,
    REG_ROUNDS = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // One item in flight: the four counter words, the key for the round it
  // meets next, and how many rounds it gets in total.
  typedef struct packed {
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    word_t                            k0;
    word_t                            k1;
    logic [RCNT_W-1:0]                rounds;
  } item_t;

endpackage

/* sv/phx_round.sv */
// ----------------------------------------------------------------------------
// Philox round stage
// One registered Philox round; the counter words pass unchanged when the
// item's round count does not reach this stage, but the key still advances.
// ----------------------------------------------------------------------------
module phx_round (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  phx_pkg::item_t             in_item,
  input  logic [phx_pkg::RCNT_W-1:0] round_idx,
  output logic                       out_valid,
  output phx_pkg::item_t             out_item
);

  logic [2*phx_pkg::WORD_W-1:0] prod_a;
  logic [2*phx_pkg::WORD_W-1:0] prod_b;
  logic                         active;
  phx_pkg::item_t               item_next;

  assign prod_a = (2*phx_pkg::WORD_W)'(in_item.words[0])
                * (2*phx_pkg::WORD_W)'(phx_pkg::MUL_A);
  assign prod_b = (2*phx_pkg::WORD_W)'(in_item.words[2])
                * (2*phx_pkg::WORD_W)'(phx_pkg::MUL_B);
  assign active = round_idx < in_item.rounds;

  always_comb begin
    item_next        = in_item;
    // The key always advances so the next stage sees its own round key.
    item_next.k0     = in_item.k0 + phx_pkg::WEYL_A;
    item_next.k1     = in_item.k1 + phx_pkg::WEYL_B;
    if (active) begin
      item_next.words[0] = prod_b[2*phx_pkg::WORD_W-1:phx_pkg::WORD_W]
                         ^ in_item.words[1] ^ in_item.k0;
      item_next.words[1] = prod_b[phx_pkg::WORD_W-1:0];
      item_next.words[2] = prod_a[2*phx_pkg::WORD_W-1:phx_pkg::WORD_W]
                         ^ in_item.words[3] ^ in_item.k1;
      item_next.words[3] = prod_a[phx_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

/* sv/philox_counter_rng.sv */
// ----------------------------------------------------------------------------
// Philox-4x32 counter RNG
// Fully pipelined Philox block cipher over a 128-bit counter stream.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel carries one 128-bit counter, and
// each transfer on the m_ channel returns the four matching random words,
// in order, one result per counter. The key and the round count (0 to 16,
// larger values act as 16) are set over the APB port while the stream is
// idle; round count 0 returns the counter unchanged.
// Throughput is one item per cycle while s_tready is high: every round has
// its own pipeline stage built around two 32x32 multipliers, so a new
// counter can enter each cycle. From the input transfer to m_tvalid an item
// passes one input register, sixteen round stages and the output register.
// Reset empties the pipeline and the output buffer and restores key 0 and
// ten rounds. When the receiver stalls, the pipeline keeps running until a
// two-entry output buffer (output register plus skid register) fills; only
// then does s_tready drop, and it rises again as soon as the skid drains.
// ----------------------------------------------------------------------------
`include "philox_counter_rng_assert.svh"

module philox_counter_rng (
  input  logic                       clk,
  input  logic                       rst,
  // Counter stream in.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [127:0]               s_tdata,  // ctr_word0, ctr_word1, ctr_word2, ctr_word3
  // Random stream out.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [127:0]               m_tdata,  // rand_word0, rand_word1, rand_word2, rand_word3
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [phx_pkg::ADDR_W-1:0] paddr,
  input  logic [phx_pkg::DATA_W-1:0] pwdata,
  output logic [phx_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  // Configuration registers.
  phx_pkg::word_t              key_word0;
  phx_pkg::word_t              key_word1;
  logic [phx_pkg::RCNT_W-1:0]  round_count;
  phx_pkg::reg_idx_t           reg_idx;
  logic                        cfg_write;

  // Pipeline: entry 0 is the input register, entry r+1 follows round r.
  logic                        stage_v [0:phx_pkg::MAX_ROUNDS];
  phx_pkg::item_t              stage_q [0:phx_pkg::MAX_ROUNDS];
  logic                        en;
  logic [phx_pkg::RCNT_W-1:0]  rounds_sat;

  // Output buffer.
  logic                        out_valid;
  logic [127:0]                out_data;
  logic                        skid_valid;
  logic [127:0]                skid_data;
  logic                        last_valid;
  logic [127:0]                last_data;

  // ---------------------------------------------------------------------------
  // APB registers. pready is tied high, so every access completes in its
  // access cycle. Writes to the unused address slot are dropped.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = phx_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0   <= '0;
      key_word1   <= '0;
      round_count <= phx_pkg::ROUNDS_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        phx_pkg::REG_KEY0:   key_word0   <= pwdata;
        phx_pkg::REG_KEY1:   key_word1   <= pwdata;
        phx_pkg::REG_ROUNDS: round_count <= pwdata[phx_pkg::RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      phx_pkg::REG_KEY0:   prdata = key_word0;
      phx_pkg::REG_KEY1:   prdata = key_word1;
      phx_pkg::REG_ROUNDS: prdata = phx_pkg::DATA_W'(round_count);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline. The whole pipeline moves together and only halts while the
  // skid register holds a result, so s_tready comes straight from a flop.
  // ---------------------------------------------------------------------------
  assign en       = !skid_valid;
  assign s_tready = en;

  assign rounds_sat = (round_count > phx_pkg::ROUNDS_MAX) ? phx_pkg::ROUNDS_MAX
                                                          : round_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v[0] <= 1'b0;
    end else if (en) begin
      stage_v[0] <= s_tvalid;
    end
  end

  // The first round uses the key as written; each stage hands the bumped
  // key to the next one.
  always_ff @(posedge clk) begin
    if (en) begin
      stage_q[0].words  <= s_tdata;
      stage_q[0].k0     <= key_word0;
      stage_q[0].k1     <= key_word1;
      stage_q[0].rounds <= rounds_sat;
    end
  end

  for (genvar g = 0; g < phx_pkg::MAX_ROUNDS; g++) begin : g_round
    phx_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_v[g]),
      .in_item   (stage_q[g]),
      .round_idx (phx_pkg::RCNT_W'(g)),
      .out_valid (stage_v[g+1]),
      .out_item  (stage_q[g+1])
    );
  end

  assign last_valid = stage_v[phx_pkg::MAX_ROUNDS];
  assign last_data  = stage_q[phx_pkg::MAX_ROUNDS].words;

  // ---------------------------------------------------------------------------
  // Output register with skid. A result leaving the pipeline while the
  // output register is stalled parks in the skid register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= last_valid;
      end
    end else if (last_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : last_data;
    end else if (last_valid && en) begin
      skid_data <= last_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The skid register only fills behind a held output register.
  `PHX_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  // A result arriving at a stalled, skid-free output must be parked.
  `PHX_ASSERT_NEXT(a_skid_catches, out_valid && !m_tready && !skid_valid && last_valid,
                   skid_valid)
  // Items enter with a saturated round count.
  `PHX_ASSERT_NOW(a_rounds_sat, stage_v[0], stage_q[0].rounds <= phx_pkg::ROUNDS_MAX)

endmodule

/* tb/philox_counter_rng_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Philox counter RNG testbench
// Streams 128-bit counters into the block under several keys and round
// counts, predicts each group of four random words in the testbench, and
// compares every output transfer with the oldest prediction. Both stream
// sides idle at random, and the output side also holds off long enough for
// the pipeline to back up into the input.
// ----------------------------------------------------------------------------
module philox_counter_rng_tb;

  localparam int CLK_HALF_NS  = 5;
  localparam int RESET_CYCLES = 4;
  // Eighteen stages from input transfer to m_tvalid, plus some margin.
  localparam int DRAIN_SLACK  = 40;
  localparam int GAP_MAX      = 18;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 1820;
  // The limit is set well above the slowest legal run.
  localparam int RUN_LIMIT_NS = 4_000_000;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [127:0]                 s_tdata;   // ctr_word0, ctr_word1, ctr_word2, ctr_word3
  logic                         m_tvalid;
  logic                         m_tready;
  logic [127:0]                 m_tdata;   // rand_word0, rand_word1, rand_word2, rand_word3
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [phx_pkg::ADDR_W-1:0]   paddr;
  logic [phx_pkg::DATA_W-1:0]   pwdata;
  logic [phx_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Testbench copy of the configuration, updated at the APB write edge.
  phx_pkg::word_t               key0_cfg;
  phx_pkg::word_t               key1_cfg;
  logic [phx_pkg::RCNT_W-1:0]   rounds_cfg;

  // Predicted random words, oldest first, one entry per accepted counter.
  logic [127:0]                 rand_expect_q[$];
  int unsigned                  mismatch_count;

  // Idle controls shared between the test tasks and the two stream sides.
  bit                           src_idle_en;
  bit                           sink_idle_en;
  int                           sink_hold_cycles;

  philox_counter_rng DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Philox-4x32 over the current key and round count. Each round multiplies
  // words 0 and 2 into 64-bit products, crosses the high halves into the
  // even words with the key mixed in, and drops the low halves into the odd
  // words. The key takes a Weyl step before every round but the first.
  function automatic logic [127:0] philox_block(input logic [127:0] ctr);
    phx_pkg::word_t w[4];
    phx_pkg::word_t k0;
    phx_pkg::word_t k1;
    phx_pkg::word_t n0;
    phx_pkg::word_t n2;
    logic [63:0]    pa;
    logic [63:0]    pb;
    int             n_rounds;
    for (int i = 0; i < 4; i++) w[i] = ctr[32*i +: 32];
    k0 = key0_cfg;
    k1 = key1_cfg;
    // Counts above the maximum act as the maximum; zero passes through.
    n_rounds = (rounds_cfg > phx_pkg::ROUNDS_MAX) ? phx_pkg::MAX_ROUNDS
                                                  : int'(rounds_cfg);
    for (int r = 0; r < n_rounds; r++) begin
      if (r > 0) begin
        k0 = k0 + phx_pkg::WEYL_A;
        k1 = k1 + phx_pkg::WEYL_B;
      end
      pa   = {32'd0, w[0]} * {32'd0, phx_pkg::MUL_A};
      pb   = {32'd0, w[2]} * {32'd0, phx_pkg::MUL_B};
      n0   = pb[63:32] ^ w[1] ^ k0;
      n2   = pa[63:32] ^ w[3] ^ k1;
      w[0] = n0;
      w[1] = pb[31:0];
      w[2] = n2;
      w[3] = pa[31:0];
    end
    return {w[3], w[2], w[1], w[0]};
  endfunction

  // Random word with extra weight on the corners of the range.
  function automatic phx_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return phx_pkg::word_t'(1) << $urandom_range(0, phx_pkg::WORD_W - 1);
      3:       return ~(phx_pkg::word_t'(1) << $urandom_range(0, phx_pkg::WORD_W - 1));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [127:0] pick_counter();
    return {pick_word(), pick_word(), pick_word(), pick_word()};
  endfunction

  // Drops the input valid and waits until every predicted result has been
  // transferred out. Since every counter yields exactly one result, an empty
  // queue means the pipeline is empty too.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (rand_expect_q.size() != 0) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle. The register takes the
  // value at the edge where psel, penable, pwrite and pready are all high,
  // and the testbench copy is updated at that same edge.
  task automatic write_reg(input phx_pkg::reg_idx_t idx,
                           input logic [phx_pkg::DATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      phx_pkg::REG_KEY0:   key0_cfg   = value;
      phx_pkg::REG_KEY1:   key1_cfg   = value;
      phx_pkg::REG_ROUNDS: rounds_cfg = value[phx_pkg::RCNT_W-1:0];
      default:             ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_key(input phx_pkg::word_t k0, input phx_pkg::word_t k1);
    write_reg(phx_pkg::REG_KEY0, k0);
    write_reg(phx_pkg::REG_KEY1, k1);
  endtask

  // Offers one counter after a random gap and holds it until the transfer.
  // With no gap, valid simply stays high from the previous transfer.
  task automatic send_counter(input logic [127:0] ctr);
    int gap;
    gap = src_idle_en ? $urandom_range(0, GAP_MAX) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= ctr;
    do @(posedge clk); while (!s_tready);
    rand_expect_q.push_back(philox_block(ctr));
  endtask

  // Receiver side. Between results it may first serve a long hold-off
  // requested by a test, then draws its own stall, then waits with m_tready
  // high for the next transfer.
  initial begin : sink_side
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (sink_hold_cycles) @(negedge clk);
        sink_hold_cycles = 0;
      end
      stall = sink_idle_en ? $urandom_range(0, GAP_MAX) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Every output transfer is checked word by word against the oldest
  // prediction. A transfer with nothing predicted is a failure as well.
  always @(posedge clk) begin : check_results
    logic [127:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (rand_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
      end else begin
        want = rand_expect_q.pop_front();
        for (int i = 0; i < phx_pkg::NUM_WORDS; i++) begin
          if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
            mismatch_count++;
            $display("%0t: rand_word%0d expected %h actual %h", $time, i,
                     want[32*i +: 32], m_tdata[32*i +: 32]);
          end
        end
      end
    end
  end

  // Hand-picked counters, most with every word at an extreme, under the reset
  // key and the default ten rounds.
  task automatic test_reset_defaults();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_counter('0);
    send_counter('1);
    send_counter({32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    send_counter({32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
    send_counter({4{32'h8000_0001}});
    send_counter({32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000});
  endtask

  // Walks the round count through zero, one, two, fifteen, the top of the range
  // and past it. Two of the counts are written with junk above bit 4, which
  // the block must drop. A write to the unused register address must
  // leave the configuration as it was.
  task automatic test_round_counts();
    set_key('1, '1);
    write_reg(phx_pkg::REG_ROUNDS, 32'd0);
    send_counter('1);
    send_counter(pick_counter());
    write_reg(phx_pkg::REG_ROUNDS, 32'd1);
    send_counter('0);
    send_counter('1);
    set_key('0, '1);
    write_reg(phx_pkg::REG_ROUNDS, 32'd2);
    send_counter(pick_counter());
    write_reg(phx_pkg::REG_ROUNDS, 32'd15);
    send_counter(pick_counter());
    write_reg(phx_pkg::REG_ROUNDS, 32'hABCD_EF10);
    send_counter('0);
    send_counter(pick_counter());
    write_reg(phx_pkg::REG_ROUNDS, 32'd17);
    send_counter(pick_counter());
    set_key('1, '0);
    write_reg(phx_pkg::REG_ROUNDS, 32'hFFFF_FFFF);
    send_counter('1);
    send_counter(pick_counter());
    write_reg(phx_pkg::REG_NONE, $urandom());
    send_counter(pick_counter());
    send_counter('0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back-to-back counters, so the pipeline and the output buffer
  // fill and s_tready has to drop.
  task automatic test_backpressure();
    set_key(pick_word(), pick_word());
    write_reg(phx_pkg::REG_ROUNDS, 32'd16);
    src_idle_en      = 1'b0;
    sink_idle_en     = 1'b0;
    sink_hold_cycles = HOLD_CYCLES;
    repeat (60) send_counter(pick_counter());
    wait_idle();
    sink_idle_en = 1'b1;
  endtask

  // Random traffic in phases. Each phase picks a key and a round count,
  // and whether each side idles. Every phase ends with the sender pausing
  // until all results are back, before the next configuration goes in.
  task automatic test_random_traffic(input int n_items);
    int                         sent;
    int                         phase_len;
    logic [phx_pkg::RCNT_W-1:0] rounds;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 7))
        0:       rounds = '0;
        1:       rounds = phx_pkg::ROUNDS_MAX;
        2:       rounds = '1;
        3:       rounds = 5'd1;
        4:       rounds = phx_pkg::ROUNDS_RESET;
        default: rounds = phx_pkg::RCNT_W'($urandom_range(0, 31));
      endcase
      set_key(pick_word(), pick_word());
      write_reg(phx_pkg::REG_ROUNDS, {27'($urandom_range(0, 32'h07FF_FFFF)), rounds});
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      phase_len    = $urandom_range(120, 300);
      if (phase_len > n_items - sent) phase_len = n_items - sent;
      repeat (phase_len) send_counter(pick_counter());
      sent += phase_len;
    end
    wait_idle();
  endtask

  // Fails the run if it has not finished within a generous time.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_sequence
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    key0_cfg         = '0;
    key1_cfg         = '0;
    rounds_cfg       = phx_pkg::ROUNDS_RESET;
    mismatch_count   = 0;
    src_idle_en      = 1'b0;
    sink_idle_en     = 1'b0;
    sink_hold_cycles = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_round_counts();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    // Everything predicted has come back; give the pipeline time to show
    // any stray result before deciding.
    wait_idle();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (mismatch_count == 0 && rand_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
